@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property.
`define CHK_PROP(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that an expression never holds.
`define CHK_NEVER(label, expr, msg) \
    `CHK_PROP(label, !(expr), msg)

`endif

@@ rtl/alsd_pkg.sv @@
package alsd_pkg;

    localparam int SCORE_W    = 21;
    localparam int COUNT_W    = 7;
    localparam int COORD_IN_W = 8;
    localparam int COORD_MAX_W = 16;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam int COUNT_MAX = 127;

    localparam logic [1:0] MODE_PAIR = 2'd0;
    localparam logic [1:0] MODE_L1   = 2'd1;
    localparam logic [1:0] MODE_LINF = 2'd2;

    localparam logic FUNC_CENTER = 1'b0;
    localparam logic FUNC_POINT  = 1'b1;

    // Control part of the token that walks down the cell chain.
    typedef struct packed {
        logic valid;
        logic pairwise;
        logic last;
    } tok_ctrl_t;

    function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                   input logic [SCORE_W-1:0] b);
        logic [SCORE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SCORE_W] ? SCORE_MAX : s[SCORE_W-1:0];
    endfunction

    function automatic logic [COORD_MAX_W-1:0] abs_diff(input logic [COORD_MAX_W-1:0] a,
                                                        input logic [COORD_MAX_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ rtl/allocation_set_distance_scorer.sv @@
// Scores a set of processor points on a 3D mesh.
// Input channel (s_*): one transaction per item. s_tuser selects a center item
// (0: load the center and clear the set) or a processor point (1). s_tlast on a
// point asks for the result once that point is scored.
// Result channel (m_*): one transaction per point marked last, carrying the
// score, the point count (saturated at 127) and the overflow flag.
// Configuration (cfg_*): the two-bit scoring mode. The user must write it only
// while the block idles; the block itself does not enforce this. A center item
// is taken without leaving idle. A point passes an entry register and walks
// down a chain of MAX_POINTS cells, one cell per cycle; the next item is taken
// once it leaves the chain. A point marked last then holds the input in the
// hold state until its result is registered. A new item is taken while a result
// is still waiting on m_tready; a point marked last that finishes while the
// previous result is still unread waits until that result is taken.
// Reset clears the mode, center, count, score and overflow flag; the stored
// points need no clearing since only those of the current set are read.
module allocation_set_distance_scorer
    import alsd_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,    // score_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // coord_x [7:0], coord_y [15:8], coord_z [23:16]
    input  logic        s_tuser,     // func
    input  logic        s_tlast,     // last_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata      // set_score [20:0], point_count [27:21], overflowed [28]
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int TAKE_W = (COORD_BITS < COORD_IN_W) ? COORD_BITS : COORD_IN_W;
    localparam int PT_W   = 3 * COORD_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t                state_reg;
    logic [1:0]            mode_reg;
    logic [PT_W-1:0]       center_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [SCORE_W-1:0]    score_reg;
    logic                  ovf_reg;
    logic                  m_tvalid_reg;
    logic [31:0]           m_tdata_reg;

    tok_ctrl_t             entry_ctrl_reg;
    logic [PT_W-1:0]       entry_pt_reg;
    logic [CNT_W-1:0]      entry_count_reg;
    logic [SCORE_W-1:0]    entry_sum_reg;

    tok_ctrl_t             ch_ctrl  [0:MAX_POINTS];
    logic [PT_W-1:0]       ch_pt    [0:MAX_POINTS];
    logic [CNT_W-1:0]      ch_count [0:MAX_POINTS];
    logic [SCORE_W-1:0]    ch_sum   [0:MAX_POINTS];

    logic                  in_acc;
    logic [PT_W-1:0]       in_pt;
    logic                  full;
    logic [COORD_BITS-1:0] dx, dy, dz, dmax;
    logic [SCORE_W-1:0]    d_l1;
    logic [SCORE_W-1:0]    center_add;
    logic [SCORE_W-1:0]    entry_sum_next;
    logic                  out_free;
    logic [COUNT_W-1:0]    count_sat;

    assign cfg_ready = aresetn;
    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign in_pt = {COORD_BITS'(s_tdata[2*COORD_IN_W +: TAKE_W]),
                    COORD_BITS'(s_tdata[COORD_IN_W +: TAKE_W]),
                    COORD_BITS'(s_tdata[0 +: TAKE_W])};

    always_comb begin
        full = (count_reg == CNT_W'(MAX_POINTS));
        dx = COORD_BITS'(abs_diff(COORD_MAX_W'(in_pt[COORD_BITS-1:0]),
                                  COORD_MAX_W'(center_reg[COORD_BITS-1:0])));
        dy = COORD_BITS'(abs_diff(COORD_MAX_W'(in_pt[2*COORD_BITS-1:COORD_BITS]),
                                  COORD_MAX_W'(center_reg[2*COORD_BITS-1:COORD_BITS])));
        dz = COORD_BITS'(abs_diff(COORD_MAX_W'(in_pt[PT_W-1:2*COORD_BITS]),
                                  COORD_MAX_W'(center_reg[PT_W-1:2*COORD_BITS])));
        d_l1 = SCORE_W'(dx) + SCORE_W'(dy) + SCORE_W'(dz);
        dmax = dx;
        if (dy > dmax) begin
            dmax = dy;
        end
        if (dz > dmax) begin
            dmax = dz;
        end
        // A point arriving on a full set scores nothing.
        if (full) begin
            center_add = '0;
        end else begin
            case (mode_reg)
                MODE_PAIR: center_add = '0;
                MODE_L1:   center_add = d_l1;
                default:   center_add = SCORE_W'(dmax);
            endcase
        end
        entry_sum_next = sat_add(score_reg, center_add);

        if (32'(count_reg) > COUNT_MAX) begin
            count_sat = COUNT_W'(COUNT_MAX);
        end else begin
            count_sat = COUNT_W'(count_reg);
        end
    end

    // Entry stage of the chain.
    always_ff @(posedge aclk) begin
        entry_pt_reg    <= in_pt;
        entry_count_reg <= count_reg;
        entry_sum_reg   <= entry_sum_next;
        if (!aresetn) begin
            entry_ctrl_reg <= '0;
        end else begin
            entry_ctrl_reg.valid    <= in_acc && (s_tuser == FUNC_POINT);
            entry_ctrl_reg.pairwise <= (mode_reg == MODE_PAIR) && !full;
            entry_ctrl_reg.last     <= s_tlast;
        end
    end

    assign ch_ctrl[0]  = entry_ctrl_reg;
    assign ch_pt[0]    = entry_pt_reg;
    assign ch_count[0] = entry_count_reg;
    assign ch_sum[0]   = entry_sum_reg;

    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        alsd_cell #(
            .CELL_IDX   (i),
            .COORD_BITS (COORD_BITS),
            .CNT_W      (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_ctrl   (ch_ctrl[i]),
            .in_pt     (ch_pt[i]),
            .in_count  (ch_count[i]),
            .in_sum    (ch_sum[i]),
            .out_ctrl  (ch_ctrl[i+1]),
            .out_pt    (ch_pt[i+1]),
            .out_count (ch_count[i+1]),
            .out_sum   (ch_sum[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_PAIR;
            center_reg   <= '0;
            count_reg    <= '0;
            score_reg    <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
            // In the hold state the new result replaces the one being taken.
            if (m_tvalid_reg && m_tready && (state_reg != ST_HOLD)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (s_tuser == FUNC_CENTER) begin
                            center_reg <= in_pt;
                            count_reg  <= '0;
                            score_reg  <= '0;
                            ovf_reg    <= 1'b0;
                        end else begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (ch_ctrl[MAX_POINTS].valid) begin
                        score_reg <= ch_sum[MAX_POINTS];
                        if (full) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= ch_ctrl[MAX_POINTS].last ? ST_HOLD : ST_IDLE;
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {3'b000, ovf_reg, count_sat, score_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `include "assert_macros.svh"

    `CHK_PROP(a_exit_in_run, ch_ctrl[MAX_POINTS].valid |-> state_reg == ST_RUN, "token left the chain outside a run")
    `CHK_NEVER(a_count_range, count_reg > CNT_W'(MAX_POINTS), "point count beyond capacity")
    `CHK_PROP(a_score_grows, (state_reg == ST_RUN && ch_ctrl[MAX_POINTS].valid) |-> ch_sum[MAX_POINTS] >= score_reg, "score decreased within a set")
    `CHK_PROP(a_result_source, $rose(m_tvalid_reg) |-> $past(state_reg) == ST_HOLD, "result raised without a finished last point")

endmodule

@@ rtl/alsd_cell.sv @@
module alsd_cell
    import alsd_pkg::*;
#(
    parameter int CELL_IDX   = 0,
    parameter int COORD_BITS = 8,
    parameter int CNT_W      = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tok_ctrl_t             in_ctrl,
    input  logic [3*COORD_BITS-1:0] in_pt,
    input  logic [CNT_W-1:0]      in_count,
    input  logic [SCORE_W-1:0]    in_sum,
    output tok_ctrl_t             out_ctrl,
    output logic [3*COORD_BITS-1:0] out_pt,
    output logic [CNT_W-1:0]      out_count,
    output logic [SCORE_W-1:0]    out_sum
);

    logic [3*COORD_BITS-1:0] store_reg;
    tok_ctrl_t               ctrl_reg;
    logic [3*COORD_BITS-1:0] pt_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [SCORE_W-1:0]      sum_reg;

    logic [COORD_BITS-1:0] dx, dy, dz;
    logic [SCORE_W-1:0]    pair_dist;
    logic [SCORE_W-1:0]    sum_next;
    logic                  hit;
    logic                  wr_en;

    always_comb begin
        dx = COORD_BITS'(abs_diff(COORD_MAX_W'(in_pt[COORD_BITS-1:0]),
                                  COORD_MAX_W'(store_reg[COORD_BITS-1:0])));
        dy = COORD_BITS'(abs_diff(COORD_MAX_W'(in_pt[2*COORD_BITS-1:COORD_BITS]),
                                  COORD_MAX_W'(store_reg[2*COORD_BITS-1:COORD_BITS])));
        dz = COORD_BITS'(abs_diff(COORD_MAX_W'(in_pt[3*COORD_BITS-1:2*COORD_BITS]),
                                  COORD_MAX_W'(store_reg[3*COORD_BITS-1:2*COORD_BITS])));
        pair_dist = SCORE_W'(dx) + SCORE_W'(dy) + SCORE_W'(dz);
        // Only cells below the count hold a point of the current set.
        hit = in_ctrl.valid && in_ctrl.pairwise && (CNT_W'(CELL_IDX) < in_count);
        sum_next = hit ? sat_add(in_sum, pair_dist) : in_sum;
        // The first free cell captures the new point as it passes.
        wr_en = in_ctrl.valid && (in_count == CNT_W'(CELL_IDX));
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg <= in_pt;
        end
        pt_reg    <= in_pt;
        count_reg <= in_count;
        sum_reg   <= sum_next;
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else begin
            ctrl_reg <= in_ctrl;
        end
    end

    assign out_ctrl  = ctrl_reg;
    assign out_pt    = pt_reg;
    assign out_count = count_reg;
    assign out_sum   = sum_reg;

endmodule
